### rtl/pid2f_pkg.sv
// ----------------------------------------------------------------------------
// pid2f_pkg
// Shared types and constants for the two-form PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pid2f_pkg;

    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int INTEG_W    = 40;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FORM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    // controller forms
    localparam logic FORM_INCR = 1'b0;
    localparam logic FORM_POS  = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10000;

    typedef struct packed {
        logic               form;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] out_limit;
    } pid2f_cfg_t;

endpackage

`default_nettype wire

### rtl/pid2f_calc.sv
// ----------------------------------------------------------------------------
// pid2f_calc
// Single-pass control law: three gain multiplies, integral saturation,
// accumulation and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pid2f_calc
    import pid2f_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  pid2f_cfg_t                                cfg,
    input  logic signed [DATA_WIDTH:0]                err_cur,
    input  logic signed [DATA_WIDTH:0]                err_prev,
    input  logic signed [DATA_WIDTH:0]                err_prev2,
    input  logic signed [INTEG_W-1:0]                 integ,
    input  logic        [LIMIT_W+GAIN_FRAC_BITS-1:0]  acc_prev,
    output logic signed [INTEG_W-1:0]                 integ_next,
    output logic        [LIMIT_W+GAIN_FRAC_BITS-1:0]  acc_next
);

    localparam int OPW      = DATA_WIDTH + 3;
    localparam int PROD_W   = GAIN_W + 1 + OPW;
    localparam int SUM_BASE = (INTEG_W > PROD_W) ? INTEG_W : PROD_W;
    localparam int ACC_W    = SUM_BASE + 3;
    localparam int OUT_W    = LIMIT_W + GAIN_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] I_MAX =
        signed'({{(ACC_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] I_MIN =
        signed'({{(ACC_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}});

    logic                      pos_form;
    logic signed [OPW-1:0]     e0_x;
    logic signed [OPW-1:0]     e1_x;
    logic signed [OPW-1:0]     e2_x;
    logic signed [OPW-1:0]     diff1;
    logic signed [OPW-1:0]     diff2;
    logic signed [OPW-1:0]     op_p;
    logic signed [OPW-1:0]     op_d;
    logic signed [GAIN_W:0]    kp_s;
    logic signed [GAIN_W:0]    ki_s;
    logic signed [GAIN_W:0]    kd_s;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROD_W-1:0]  prod_d;
    logic signed [ACC_W-1:0]   p_x;
    logic signed [ACC_W-1:0]   i_x;
    logic signed [ACC_W-1:0]   d_x;
    logic signed [ACC_W-1:0]   integ_x;
    logic signed [ACC_W-1:0]   acc_x;
    logic signed [ACC_W-1:0]   isum_raw;
    logic signed [ACC_W-1:0]   isum_sat;
    logic signed [ACC_W-1:0]   sum;
    logic        [OUT_W-1:0]   lim_u;
    logic signed [ACC_W-1:0]   lim_x;

    assign pos_form = (cfg.form == FORM_POS);

    assign e0_x  = OPW'(err_cur);
    assign e1_x  = OPW'(err_prev);
    assign e2_x  = OPW'(err_prev2);
    assign diff1 = e0_x - e1_x;
    assign diff2 = e0_x - (e1_x <<< 1) + e2_x;

    // multipliers are shared between forms by steering the error operand
    assign op_p = pos_form ? e0_x  : diff1;
    assign op_d = pos_form ? diff1 : diff2;

    assign kp_s = signed'({1'b0, cfg.gain_p});
    assign ki_s = signed'({1'b0, cfg.gain_i});
    assign kd_s = signed'({1'b0, cfg.gain_d});

    assign prod_p = kp_s * op_p;
    assign prod_i = ki_s * e0_x;
    assign prod_d = kd_s * op_d;

    assign p_x     = ACC_W'(prod_p);
    assign i_x     = ACC_W'(prod_i);
    assign d_x     = ACC_W'(prod_d);
    assign integ_x = ACC_W'(integ);
    assign acc_x   = signed'(ACC_W'(acc_prev));

    // incremental form reloads the integral with this sample's term
    assign isum_raw = pos_form ? (integ_x + i_x) : i_x;

    always_comb
    begin
        if (isum_raw > I_MAX)
            isum_sat = I_MAX;
        else if (isum_raw < I_MIN)
            isum_sat = I_MIN;
        else
            isum_sat = isum_raw;
    end

    assign sum = pos_form ? (p_x + isum_sat + d_x) : (acc_x + p_x + i_x + d_x);

    assign lim_u = OUT_W'(cfg.out_limit) << GAIN_FRAC_BITS;
    assign lim_x = signed'(ACC_W'(lim_u));

    // upper clamp first, then floor at zero
    always_comb
    begin
        if (sum >= lim_x)
            acc_next = lim_u;
        else if (sum[ACC_W-1] || (sum == '0))
            acc_next = '0;
        else
            acc_next = sum[OUT_W-1:0];
    end

    assign integ_next = isum_sat[INTEG_W-1:0];

endmodule

`default_nettype wire

### rtl/pid_controller_two_form.sv
// ----------------------------------------------------------------------------
// pid_controller_two_form
// Fixed-point PID controller with incremental and positional forms.
// ----------------------------------------------------------------------------
// One sample (setpoint, measured) is taken per clock and one clamped drive
// value comes back for each, in order, on the output from the result register:
// the error is registered on entry, and the full control law (three
// gain multiplies, integral saturation, accumulate and clamp) runs in a single
// pass into the result register, which also updates the error history,
// integral and stored output. Sustained rate is one sample per cycle while
// out_stall is low; the critical path is the gain multiply followed by the
// accumulate and clamp. Configuration is written through
// cfg_write/cfg_index/cfg_data and should only change while no sample is in
// flight.
`default_nettype none

module pid_controller_two_form
    import pid2f_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    input  logic signed [DATA_WIDTH-1:0] measured,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [LIMIT_W-1:0]           drive
);

    localparam int EW    = DATA_WIDTH + 1;
    localparam int OUT_W = LIMIT_W + GAIN_FRAC_BITS;

    pid2f_cfg_t                cfg_reg;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic signed [EW-1:0]      s1_err_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [LIMIT_W-1:0]        drive_reg;

    logic signed [EW-1:0]      err1_reg;
    logic signed [EW-1:0]      err2_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic [OUT_W-1:0]          acc_reg;
    logic [OUT_W-1:0]          acc_next;

    logic                      in_take;
    logic                      advance;
    logic signed [EW-1:0]      err_in;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.form      <= FORM_INCR;
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.out_limit <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FORM:   cfg_reg.form      <= cfg_data[0];
                REG_GAIN_P: cfg_reg.gain_p    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I: cfg_reg.gain_i    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D: cfg_reg.gain_d    <= cfg_data[GAIN_W-1:0];
                REG_LIMIT:  cfg_reg.out_limit <= cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    // request flow: entry register, then result register
    assign advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    assign err_in = EW'(setpoint) - EW'(measured);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_err_reg <= err_in;
        if (advance)
            drive_reg <= acc_next[OUT_W-1:GAIN_FRAC_BITS];
    end

    // controller state moves only when a request reaches the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err1_reg  <= '0;
            err2_reg  <= '0;
            integ_reg <= '0;
            acc_reg   <= '0;
        end
        else if (advance)
        begin
            err1_reg  <= s1_err_reg;
            err2_reg  <= err1_reg;
            integ_reg <= integ_next;
            acc_reg   <= acc_next;
        end
    end

    pid2f_calc #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_calc (
        .cfg        (cfg_reg),
        .err_cur    (s1_err_reg),
        .err_prev   (err1_reg),
        .err_prev2  (err2_reg),
        .integ      (integ_reg),
        .acc_prev   (acc_reg),
        .integ_next (integ_next),
        .acc_next   (acc_next)
    );

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty entry register");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_drive_matches_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg == acc_reg[OUT_W-1:GAIN_FRAC_BITS]))
        else $error("drive out of step with stored output");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (err1_reg == $past(s1_err_reg)) && (err2_reg == $past(err1_reg)))
        else $error("error history not shifted on advance");
`endif

endmodule

`default_nettype wire

### test/tb_pid_controller_two_form.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_two_form
// Self-checking bench for the two-form PID controller. A scoreboard class
// keeps its own copy of the gains, error history, integral and stored output,
// predicts the drive value for every accepted request and compares results
// in order. Directed samples cover field extremes, zero limit and both forms.
// An integral wind-up run drives the sum into saturation both ways. Random
// phases follow, with random settings, random idling on both sides, one
// stretch without idling and one long output hold that backs up the input.
// ----------------------------------------------------------------------------

class drive_scoreboard;

    localparam int FRAC_BITS = 8;
    localparam longint INTEG_TOP    = (longint'(1) << (pid2f_pkg::INTEG_W - 1)) - 1;
    localparam longint INTEG_BOTTOM = -(longint'(1) << (pid2f_pkg::INTEG_W - 1));

    logic                             form;
    logic [pid2f_pkg::GAIN_W-1:0]     kp;
    logic [pid2f_pkg::GAIN_W-1:0]     ki;
    logic [pid2f_pkg::GAIN_W-1:0]     kd;
    logic [pid2f_pkg::LIMIT_W-1:0]    limit;

    longint err1;
    longint err2;
    longint integ;
    longint acc_out;

    logic [pid2f_pkg::LIMIT_W-1:0] drive_q[$];
    int mismatches;

    function new();
        form       = pid2f_pkg::FORM_INCR;
        kp         = '0;
        ki         = '0;
        kd         = '0;
        limit      = pid2f_pkg::LIMIT_RESET;
        err1       = 0;
        err2       = 0;
        integ      = 0;
        acc_out    = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [pid2f_pkg::CFG_IDX_W-1:0] idx,
                          logic [pid2f_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pid2f_pkg::REG_FORM:   form  = data[0];
            pid2f_pkg::REG_GAIN_P: kp    = data;
            pid2f_pkg::REG_GAIN_I: ki    = data;
            pid2f_pkg::REG_GAIN_D: kd    = data;
            pid2f_pkg::REG_LIMIT:  limit = data[pid2f_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function longint clip_integral(longint v);
        if (v > INTEG_TOP)
            return INTEG_TOP;
        if (v < INTEG_BOTTOM)
            return INTEG_BOTTOM;
        return v;
    endfunction

    // one request in, one expected drive value queued
    function void note_sample(logic signed [15:0] sp, logic signed [15:0] mv);
        longint e0;
        longint p;
        longint i;
        longint d;
        longint iterm;
        longint lim;
        longint acc;
        e0    = longint'(sp) - longint'(mv);
        p     = kp;
        i     = ki;
        d     = kd;
        lim   = limit;
        lim   = lim << FRAC_BITS;
        iterm = i * e0;
        if (form == pid2f_pkg::FORM_INCR)
        begin
            acc   = acc_out + p * (e0 - err1) + iterm + d * (e0 - 2 * err1 + err2);
            integ = clip_integral(iterm);
        end
        else
        begin
            integ = clip_integral(integ + iterm);
            acc   = p * e0 + integ + d * (e0 - err1);
        end
        err2 = err1;
        err1 = e0;
        // limit first, then floor at zero
        if (acc >= lim)
            acc = lim;
        if (acc <= 0)
            acc = 0;
        acc_out = acc;
        drive_q.push_back(acc[FRAC_BITS +: pid2f_pkg::LIMIT_W]);
    endfunction

    function void check_drive(logic [pid2f_pkg::LIMIT_W-1:0] got);
        logic [pid2f_pkg::LIMIT_W-1:0] want;
        if (drive_q.size() == 0)
        begin
            $error("drive returned with no request pending: actual %0d", got);
            mismatches++;
        end
        else
        begin
            want = drive_q.pop_front();
            if (got !== want)
            begin
                $error("drive mismatch: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return drive_q.size();
    endfunction

endclass

module tb_pid_controller_two_form;

    import pid2f_pkg::*;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 8;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic                     out_valid;
    logic                     out_stall;
    logic [LIMIT_W-1:0]       drive;

    bit quiet;

    drive_scoreboard sb = new();

    pid_controller_two_form #(
        .DATA_WIDTH     (DATA_W),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .setpoint  (setpoint),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls plus one long hold once traffic is flowing
    initial
    begin
        int  hold_left;
        int  seen;
        bit  held;
        hold_left = 0;
        seen      = 0;
        held      = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_drive(drive);
                seen++;
            end
            if (!held && seen >= 500)
            begin
                held      = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(99) < 17)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // writes every register, plus one unused index that must be ignored
    task automatic program_regs(input logic form, input int p, input int i, input int d,
                                input int lim);
        logic [CFG_IDX_W-1:0] junk_idx;
        junk_idx = CFG_IDX_W'(REG_LIMIT + 1 + $urandom_range(2));
        write_reg(junk_idx, 16'($urandom));
        write_reg(REG_FORM, {15'($urandom), form});
        write_reg(REG_GAIN_P, 16'(p));
        write_reg(REG_GAIN_I, 16'(i));
        write_reg(REG_GAIN_D, 16'(d));
        // top bit of the limit write is junk, the register is 15 bits
        write_reg(REG_LIMIT, {1'($urandom), 15'(lim)});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // a random idle gap before about one request in twelve, none while quiet
    task automatic send_sample(input int sp, input int mv);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        setpoint <= 16'(sp);
        measured <= 16'(mv);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(16'(sp), 16'(mv));
    endtask

    task automatic send_random();
        int r;
        int sp;
        int mv;
        int edges[5];
        edges = '{-32768, -1, 0, 1, 32767};
        r = $urandom_range(9);
        if (r < 4)
        begin
            // small error around a random setpoint keeps the output off the rails
            sp = int'($urandom_range(65535)) - 32768;
            mv = sp + int'($urandom_range(400)) - 200;
            if (mv > 32767 || mv < -32768)
                mv = sp;
        end
        else if (r < 8)
        begin
            sp = int'($urandom_range(65535)) - 32768;
            mv = int'($urandom_range(65535)) - 32768;
        end
        else
        begin
            sp = edges[$urandom_range(4)];
            mv = edges[$urandom_range(4)];
        end
        send_sample(sp, mv);
    endtask

    function automatic int pick_gain();
        if ($urandom_range(3) == 0)
            return $urandom_range(65535);
        return $urandom_range(767);
    endfunction

    function automatic int pick_limit();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 32767;
        return $urandom_range(32767);
    endfunction

    // drop valid and wait for every outstanding request to come back
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_FORM;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        setpoint  <= '0;
        measured  <= '0;
        quiet      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all gains zero
        send_sample(0, 0);
        send_sample(32767, -32768);
        settle();

        program_regs(FORM_INCR, 256, 64, 128, 10000);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(0, 0);
        send_sample(100, 50);
        send_sample(-1, -1);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(1000, 0);
        send_sample(0, 1000);
        settle();

        // zero limit pins the output at zero
        program_regs(FORM_INCR, 65535, 65535, 65535, 0);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        settle();

        program_regs(FORM_POS, 65535, 65535, 65535, 32767);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(5, 0);
        send_sample(0, 0);
        settle();

        // integral wind-up: saturate high, then low, then recover
        program_regs(FORM_POS, 0, 65535, 0, 32767);
        repeat (140) send_sample(32767, -32768);
        repeat (280) send_sample(-32768, 32767);
        repeat (140) send_sample(32767, -32768);
        settle();

        for (int ph = 0; ph < 11; ph++)
        begin
            quiet = (ph == 4);
            program_regs(1'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain(),
                         pick_limit());
            repeat (120) send_random();
            settle();
        end
        quiet = 1'b0;

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
